FILE: rtl/core/lrsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Least-refcount slot allocator package
// Shared constants, result codes, sequencer states and inter-module structs.
// ----------------------------------------------------------------------------
package lrsa_pkg;

    localparam int NUM_SLOTS  = 32;
    localparam int KEY_BITS   = 16;
    localparam int COUNT_BITS = 16;

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int LEN_W  = $clog2(NUM_SLOTS + 1);

    localparam int IDX_FIELD_W = 5;
    localparam int KEY_FIELD_W = 16;
    localparam int CNT_FIELD_W = 16;
    localparam int REQ_W       = 6;
    localparam int KIND_W      = 2;
    localparam int START_W     = 5;
    localparam int RUN_W       = 6;

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_ALLOC = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_EVICT    = 2'd0,
        KIND_ALLOC    = 2'd1,
        KIND_TOO_LONG = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DECIDE,
        S_EV_OUT,
        S_FIN_OUT
    } t_seq_state;

    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     idx;
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] cnt;
    } t_slot_wr;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] idx;
    } t_rd_req;

    typedef struct packed {
        logic                  en;
        logic [SLOT_W-1:0]     idx;
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] cnt;
    } t_slot_rd;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] start;
        logic [LEN_W-1:0]  len;
    } t_evict;

    typedef struct packed {
        logic              win_found;
        logic [SLOT_W-1:0] win_start;
        logic              best_found;
        logic [SLOT_W-1:0] best_start;
        logic [LEN_W-1:0]  best_len;
    } t_scan_res;

endpackage
`default_nettype wire

FILE: rtl/core/lrsa_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Slot store
// Valid flags in flip-flops, key and count memories with one registered read
// port, and a range clear of the valid flags for an eviction.
// ----------------------------------------------------------------------------
module lrsa_slot_store import lrsa_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_slot_wr i_wr,
    input  wire t_evict   i_evict,
    input  wire t_rd_req  i_rd,
    output t_slot_rd      o_rd
);

    logic [NUM_SLOTS-1:0]  r_valid;
    logic [NUM_SLOTS-1:0]  clr_mask;
    logic [KEY_BITS-1:0]   mem_key [NUM_SLOTS];
    logic [COUNT_BITS-1:0] mem_cnt [NUM_SLOTS];
    logic                  r_rd_en;
    logic [SLOT_W-1:0]     r_rd_idx;
    logic                  r_rd_valid;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [COUNT_BITS-1:0] r_rd_cnt;
    logic [LEN_W:0]        lo;
    logic [LEN_W:0]        hi;

    always_comb begin
        lo = (LEN_W+1)'(i_evict.start);
        hi = lo + (LEN_W+1)'(i_evict.len);
        for (int i = 0; i < NUM_SLOTS; i++) begin
            clr_mask[i] = ((LEN_W+1)'(i) >= lo) && ((LEN_W+1)'(i) < hi);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.idx] <= i_wr.valid;
        end else if (i_evict.en) begin
            r_valid <= r_valid & ~clr_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem_key[i_wr.idx] <= i_wr.key;
            mem_cnt[i_wr.idx] <= i_wr.cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key   <= mem_key[i_rd.idx];
        r_rd_cnt   <= mem_cnt[i_rd.idx];
        r_rd_valid <= r_valid[i_rd.idx];
        r_rd_idx   <= i_rd.idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_en <= 1'b0;
        end else begin
            r_rd_en <= i_rd.en;
        end
    end

    assign o_rd.en    = r_rd_en;
    assign o_rd.idx   = r_rd_idx;
    assign o_rd.valid = r_rd_valid;
    assign o_rd.key   = r_rd_key;
    assign o_rd.cnt   = r_rd_cnt;

endmodule
`default_nettype wire

FILE: rtl/core/lrsa_run_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Run scan unit
// Takes one slot per cycle in ascending order and tracks the lowest free
// window of the requested length and the run with the smallest count.
// ----------------------------------------------------------------------------
module lrsa_run_scan import lrsa_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_clr,
    input  wire logic [LEN_W-1:0] i_req,
    input  wire t_slot_rd         i_slot,
    output t_scan_res             o_res
);

    logic                  r_win_found;
    logic [SLOT_W-1:0]     r_win_start;
    logic [LEN_W-1:0]      r_avail;
    logic                  r_prev_valid;
    logic [KEY_BITS-1:0]   r_prev_key;
    logic                  r_best_found;
    logic [COUNT_BITS-1:0] r_best_cnt;
    logic [SLOT_W-1:0]     r_best_start;
    logic [LEN_W-1:0]      r_best_len;
    logic                  r_track;

    logic                  cont;
    logic                  run_start;
    logic                  better;
    logic [LEN_W-1:0]      avail_inc;
    logic [LEN_W:0]        win_calc;

    always_comb begin
        cont      = i_slot.valid && r_prev_valid && (i_slot.key == r_prev_key);
        run_start = i_slot.valid && !cont;
        better    = !r_best_found || (i_slot.cnt < r_best_cnt);
        avail_inc = r_avail + LEN_W'(1);
        win_calc  = (LEN_W+1)'(i_slot.idx) + (LEN_W+1)'(1) - (LEN_W+1)'(i_req);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_win_found  <= 1'b0;
            r_win_start  <= '0;
            r_avail      <= '0;
            r_prev_valid <= 1'b0;
            r_prev_key   <= '0;
            r_best_found <= 1'b0;
            r_best_cnt   <= '0;
            r_best_start <= '0;
            r_best_len   <= '0;
            r_track      <= 1'b0;
        end else if (i_slot.en) begin
            r_prev_valid <= i_slot.valid;
            r_prev_key   <= i_slot.key;
            if (!r_win_found) begin
                if (i_slot.valid) begin
                    r_avail <= '0;
                end else begin
                    r_avail <= avail_inc;
                    if (avail_inc == i_req) begin
                        r_win_found <= 1'b1;
                        r_win_start <= SLOT_W'(win_calc);
                    end
                end
            end
            if (run_start && better) begin
                r_best_found <= 1'b1;
                r_best_cnt   <= i_slot.cnt;
                r_best_start <= i_slot.idx;
                r_best_len   <= LEN_W'(1);
                r_track      <= 1'b1;
            end else if (cont) begin
                if (r_track) begin
                    r_best_len <= r_best_len + LEN_W'(1);
                end
            end else begin
                r_track <= 1'b0;
            end
        end
    end

    assign o_res.win_found  = r_win_found;
    assign o_res.win_start  = r_win_start;
    assign o_res.best_found = r_best_found;
    assign o_res.best_start = r_best_start;
    assign o_res.best_len   = r_best_len;

endmodule
`default_nettype wire

FILE: rtl/core/lrsa_seq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocation sequencer
// Accepts items, writes slots, runs scan passes, issues evictions and holds
// the result register and the write-back configuration bit.
// ----------------------------------------------------------------------------
module lrsa_seq import lrsa_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_mode,
    input  wire logic [IDX_FIELD_W-1:0] i_slot_index,
    input  wire logic                   i_new_valid,
    input  wire logic [KEY_FIELD_W-1:0] i_new_key,
    input  wire logic [CNT_FIELD_W-1:0] i_new_refcount,
    input  wire logic [REQ_W-1:0]       i_requested_slots,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [KIND_W-1:0]           o_kind,
    output logic [START_W-1:0]          o_start_slot,
    output logic [RUN_W-1:0]            o_run_length,
    output logic                        o_last,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata,
    output t_slot_wr                    o_wr,
    output t_evict                      o_evict,
    output t_rd_req                     o_rd,
    output logic                        o_clr,
    output logic [LEN_W-1:0]            o_req,
    input  wire t_scan_res              i_res
);

    t_seq_state           r_state, n_state;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic [LEN_W-1:0]     r_req, n_req;
    logic                 r_out_valid, n_out_valid;
    t_kind                r_kind, n_kind;
    logic [START_W-1:0]   r_start, n_start;
    logic [RUN_W-1:0]     r_len, n_len;
    logic                 r_last, n_last;
    logic                 r_write_back;
    logic                 out_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_out_valid  <= 1'b0;
            r_write_back <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_write_back <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_req   <= n_req;
        r_kind  <= n_kind;
        r_start <= n_start;
        r_len   <= n_len;
        r_last  <= n_last;
    end

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_req       = r_req;
        n_out_valid = r_out_valid;
        n_kind      = r_kind;
        n_start     = r_start;
        n_len       = r_len;
        n_last      = r_last;
        o_in_ready  = 1'b0;
        o_wr        = '0;
        o_evict     = '0;
        o_rd        = '0;
        o_clr       = 1'b0;
        out_acc     = r_out_valid && i_out_ready;

        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_mode == MODE_WRITE) begin
                        o_wr.en    = (32'(i_slot_index) < NUM_SLOTS);
                        o_wr.idx   = SLOT_W'(i_slot_index);
                        o_wr.valid = i_new_valid;
                        o_wr.key   = KEY_BITS'(i_new_key);
                        o_wr.cnt   = COUNT_BITS'(i_new_refcount);
                    end else if (i_requested_slots == '0) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_ALLOC;
                        n_start     = '0;
                        n_len       = '0;
                        n_last      = 1'b1;
                        n_state     = S_FIN_OUT;
                    end else if (32'(i_requested_slots) > NUM_SLOTS) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_TOO_LONG;
                        n_start     = '0;
                        n_len       = '0;
                        n_last      = 1'b1;
                        n_state     = S_FIN_OUT;
                    end else begin
                        n_req   = LEN_W'(i_requested_slots);
                        o_clr   = 1'b1;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (i_res.win_found) begin
                    n_state = S_DECIDE;
                end else begin
                    o_rd.en  = 1'b1;
                    o_rd.idx = r_idx;
                    if (r_idx == SLOT_W'(NUM_SLOTS - 1)) begin
                        n_state = S_DRAIN;
                    end else begin
                        n_idx = r_idx + SLOT_W'(1);
                    end
                end
            end
            S_DRAIN: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_res.win_found) begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_ALLOC;
                    n_start     = START_W'(i_res.win_start);
                    n_len       = RUN_W'(r_req);
                    n_last      = 1'b1;
                    n_state     = S_FIN_OUT;
                end else if (i_res.best_found) begin
                    o_evict.en    = 1'b1;
                    o_evict.start = i_res.best_start;
                    o_evict.len   = i_res.best_len;
                    if (r_write_back) begin
                        n_out_valid = 1'b1;
                        n_kind      = KIND_EVICT;
                        n_start     = START_W'(i_res.best_start);
                        n_len       = RUN_W'(i_res.best_len);
                        n_last      = 1'b0;
                        n_state     = S_EV_OUT;
                    end else begin
                        o_clr   = 1'b1;
                        n_idx   = '0;
                        n_state = S_SCAN;
                    end
                end else begin
                    n_out_valid = 1'b1;
                    n_kind      = KIND_TOO_LONG;
                    n_start     = '0;
                    n_len       = '0;
                    n_last      = 1'b1;
                    n_state     = S_FIN_OUT;
                end
            end
            S_EV_OUT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    o_clr       = 1'b1;
                    n_idx       = '0;
                    n_state     = S_SCAN;
                end
            end
            S_FIN_OUT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b0;
            end
        endcase
    end

    assign o_req        = r_req;
    assign o_out_valid  = r_out_valid;
    assign o_kind       = r_kind;
    assign o_start_slot = r_start;
    assign o_run_length = r_len;
    assign o_last       = r_last;

endmodule
`default_nettype wire

FILE: rtl/core/least_refcount_slot_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// A write item is taken in the idle state and the block is ready again in the next cycle.
// An allocate item runs scan passes (one slot per cycle through the memory read
// port), one pass per eviction plus a final one, and output stalls hold it up
// further.
// Reset is synchronous: all slots become invalid and write-back is enabled.
// The key and count memories are not cleared; only the keys and counts of valid slots are ever used.
// ----------------------------------------------------------------------------
// Least-refcount slot allocator
// Allocates contiguous free slots in one bucket, evicting the run with the
// smallest reference count until a window of the requested length is free.
// ----------------------------------------------------------------------------
module least_refcount_slot_allocator import lrsa_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_mode,
    input  wire logic [IDX_FIELD_W-1:0] i_slot_index,
    input  wire logic                   i_new_valid,
    input  wire logic [KEY_FIELD_W-1:0] i_new_key,
    input  wire logic [CNT_FIELD_W-1:0] i_new_refcount,
    input  wire logic [REQ_W-1:0]       i_requested_slots,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic [KIND_W-1:0]           o_kind,
    output logic [START_W-1:0]          o_start_slot,
    output logic [RUN_W-1:0]            o_run_length,
    output logic                        o_last,
    input  wire logic                   i_cfg_we,
    input  wire logic                   i_cfg_wdata
);

    t_slot_wr         wr;
    t_evict           evict;
    t_rd_req          rd;
    t_slot_rd         slot;
    t_scan_res        res;
    logic             clr;
    logic [LEN_W-1:0] req;

    lrsa_slot_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_evict (evict),
        .i_rd    (rd),
        .o_rd    (slot)
    );

    lrsa_run_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (clr),
        .i_req   (req),
        .i_slot  (slot),
        .o_res   (res)
    );

    lrsa_seq u_seq (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_slot_index      (i_slot_index),
        .i_new_valid       (i_new_valid),
        .i_new_key         (i_new_key),
        .i_new_refcount    (i_new_refcount),
        .i_requested_slots (i_requested_slots),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_start_slot      (o_start_slot),
        .o_run_length      (o_run_length),
        .o_last            (o_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata),
        .o_wr              (wr),
        .o_evict           (evict),
        .o_rd              (rd),
        .o_clr             (clr),
        .o_req             (req),
        .i_res             (res)
    );

endmodule
`default_nettype wire

FILE: rtl/core/lrsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Allocator port checker
// Checks result hold, busy and field rules seen on the top-level ports.
// ----------------------------------------------------------------------------
module lrsa_checker import lrsa_pkg::*; (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   o_in_ready,
    input wire logic                   o_out_valid,
    input wire logic                   i_out_ready,
    input wire logic [KIND_W-1:0]      o_kind,
    input wire logic [START_W-1:0]     o_start_slot,
    input wire logic [RUN_W-1:0]       o_run_length,
    input wire logic                   o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_start_slot) && $stable(o_run_length) && $stable(o_last))
        else $error("Result changed before its transfer.");

    a_busy_with_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("Input ready while a result is pending.");

    a_evict_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_EVICT) |-> !o_last && (o_run_length != '0))
        else $error("Eviction result marked last or empty.");

    a_final_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_EVICT) |-> o_last)
        else $error("Final result not marked last.");

    a_too_long_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_TOO_LONG)
            |-> (o_start_slot == '0) && (o_run_length == '0))
        else $error("Rejected request carries a nonzero slot or length.");

endmodule

bind least_refcount_slot_allocator lrsa_checker u_lrsa_checker (.*);
`default_nettype wire

FILE: tb/tb_least_refcount_slot_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Least-refcount slot allocator testbench
// Drives write and allocate transfers with random gaps on both channels and
// predicts every eviction and allocation result with a scoreboard that keeps
// its own copy of the bucket. Covers both write-back settings, the extremes of
// every field, tied counts, full buckets of single-slot runs, and a long
// receiver stall that backs up the input channel.
// ----------------------------------------------------------------------------
package lrsa_tb_pkg;
    import lrsa_pkg::*;

    typedef struct packed {
        logic                   mode;
        logic [IDX_FIELD_W-1:0] slot_index;
        logic                   new_valid;
        logic [KEY_FIELD_W-1:0] new_key;
        logic [CNT_FIELD_W-1:0] new_refcount;
        logic [REQ_W-1:0]       requested_slots;
    } t_alloc_item;

    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start_slot;
        logic [RUN_W-1:0]   run_length;
        logic               last;
    } t_alloc_result;

    class alloc_scoreboard;
        logic                  slot_live [NUM_SLOTS];
        logic [KEY_BITS-1:0]   slot_key [NUM_SLOTS];
        logic [COUNT_BITS-1:0] slot_count [NUM_SLOTS];
        logic                  write_back;
        t_alloc_result         pending_results[$];
        int                    n_errors;
        int                    n_checked;
        int                    n_items;
        int                    n_allocs;
        int                    n_evictions;

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                slot_live[i]  = 1'b0;
                slot_key[i]   = '0;
                slot_count[i] = '0;
            end
            write_back  = 1'b1;
            n_errors    = 0;
            n_checked   = 0;
            n_items     = 0;
            n_allocs    = 0;
            n_evictions = 0;
        endfunction

        function void set_write_back(logic value);
            write_back = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void queue_outcome(t_kind kind, int start, int len, logic last);
            t_alloc_result r;
            r.kind       = kind;
            r.start_slot = START_W'(start);
            r.run_length = RUN_W'(len);
            r.last       = last;
            pending_results.push_back(r);
        endfunction

        // Called for every accepted input transfer.
        function void predict_item(t_alloc_item it);
            int                    run_first [NUM_SLOTS];
            int                    run_len [NUM_SLOTS];
            logic [COUNT_BITS-1:0] run_cnt [NUM_SLOTS];
            bit                    run_gone [NUM_SLOTS];
            int                    n_runs;
            int                    s;
            int                    b;
            int                    r;
            int                    avail;
            int                    best;
            int                    req;
            bit                    found;
            n_items++;
            if (it.mode == MODE_WRITE) begin
                slot_live[it.slot_index]  = it.new_valid;
                slot_key[it.slot_index]   = it.new_key;
                slot_count[it.slot_index] = it.new_refcount;
                return;
            end
            n_allocs++;
            req = it.requested_slots;
            if (req > NUM_SLOTS) begin
                queue_outcome(KIND_TOO_LONG, 0, 0, 1'b1);
                return;
            end
            // The runs are taken once, as the bucket stands at acceptance.
            n_runs = 0;
            s = 0;
            while (s < NUM_SLOTS) begin
                if (!slot_live[s]) begin
                    s++;
                end else begin
                    b = s;
                    while (s < NUM_SLOTS && slot_live[s] && slot_key[s] == slot_key[b])
                        s++;
                    run_first[n_runs] = b;
                    run_len[n_runs]   = s - b;
                    run_cnt[n_runs]   = slot_count[b];
                    run_gone[n_runs]  = 1'b0;
                    n_runs++;
                end
            end
            forever begin
                avail = 0;
                for (s = 0; s < NUM_SLOTS; s++) begin
                    if (avail >= req)
                        break;
                    if (!slot_live[s])
                        avail++;
                    else
                        avail = 0;
                end
                if (avail >= req) begin
                    queue_outcome(KIND_ALLOC, s - avail, req, 1'b1);
                    return;
                end
                found = 1'b0;
                best = 0;
                for (r = 0; r < n_runs; r++) begin
                    if (!run_gone[r] && (!found || run_cnt[r] < run_cnt[best])) begin
                        best = r;
                        found = 1'b1;
                    end
                end
                if (!found) begin
                    queue_outcome(KIND_TOO_LONG, 0, 0, 1'b1);
                    return;
                end
                run_gone[best] = 1'b1;
                for (s = run_first[best]; s < run_first[best] + run_len[best]; s++)
                    slot_live[s] = 1'b0;
                n_evictions++;
                if (write_back)
                    queue_outcome(KIND_EVICT, run_first[best], run_len[best], 1'b0);
            end
        endfunction

        // Called for every accepted output transfer.
        function void check_result(t_alloc_result got);
            t_alloc_result want;
            if (pending_results.size() == 0) begin
                $error("Unexpected result: kind %0d start %0d length %0d last %0d",
                       got.kind, got.start_slot, got.run_length, got.last);
                n_errors++;
                return;
            end
            want = pending_results.pop_front();
            n_checked++;
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, actual %0d", want.kind, got.kind);
                n_errors++;
            end
            if (got.start_slot !== want.start_slot) begin
                $error("start_slot: expected %0d, actual %0d", want.start_slot, got.start_slot);
                n_errors++;
            end
            if (got.run_length !== want.run_length) begin
                $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
                n_errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, actual %0d", want.last, got.last);
                n_errors++;
            end
        endfunction
    endclass
endpackage

module tb_least_refcount_slot_allocator;
    import lrsa_pkg::*;
    import lrsa_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 2000000;
    localparam int SETTLE_WAIT  = 40;
    localparam int DRAIN_WAIT   = 80;
    localparam int HOLD_CYCLES  = 400;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic                   i_mode;
    logic [IDX_FIELD_W-1:0] i_slot_index;
    logic                   i_new_valid;
    logic [KEY_FIELD_W-1:0] i_new_key;
    logic [CNT_FIELD_W-1:0] i_new_refcount;
    logic [REQ_W-1:0]       i_requested_slots;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [KIND_W-1:0]      o_kind;
    logic [START_W-1:0]     o_start_slot;
    logic [RUN_W-1:0]       o_run_length;
    logic                   o_last;
    logic                   i_cfg_we;
    logic                   i_cfg_wdata;

    alloc_scoreboard bucket_sb;
    bit              idle_on;
    bit              hold_request;
    int              cycle_count;

    least_refcount_slot_allocator u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_mode            (i_mode),
        .i_slot_index      (i_slot_index),
        .i_new_valid       (i_new_valid),
        .i_new_key         (i_new_key),
        .i_new_refcount    (i_new_refcount),
        .i_requested_slots (i_requested_slots),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_start_slot      (o_start_slot),
        .o_run_length      (o_run_length),
        .o_last            (o_last),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT) begin
                $display("Timeout after %0d cycles", cycle_count);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Result side: checks every output transfer and paces o_out_ready.
    initial begin : result_side
        int hold_left;
        int gap_left;
        t_alloc_result got;
        hold_left = 0;
        gap_left = 0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (i_out_ready && o_out_valid) begin
                got.kind       = t_kind'(o_kind);
                got.start_slot = o_start_slot;
                got.run_length = o_run_length;
                got.last       = o_last;
                bucket_sb.check_result(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                i_out_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                gap_left = pick_gap() - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Called at a rising edge; returns at the edge where the transfer happened.
    task automatic send_item(input t_alloc_item it);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_mode            <= it.mode;
        i_slot_index      <= it.slot_index;
        i_new_valid       <= it.new_valid;
        i_new_key         <= it.new_key;
        i_new_refcount    <= it.new_refcount;
        i_requested_slots <= it.requested_slots;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bucket_sb.predict_item(it);
    endtask

    task automatic send_write(input int idx, input logic valid, input logic [KEY_BITS-1:0] key,
                              input logic [COUNT_BITS-1:0] cnt);
        t_alloc_item it;
        it.mode            = MODE_WRITE;
        it.slot_index      = IDX_FIELD_W'(idx);
        it.new_valid       = valid;
        it.new_key         = key;
        it.new_refcount    = cnt;
        it.requested_slots = REQ_W'($urandom);
        send_item(it);
    endtask

    task automatic send_alloc(input int req);
        t_alloc_item it;
        it.mode            = MODE_ALLOC;
        it.slot_index      = IDX_FIELD_W'($urandom);
        it.new_valid       = 1'($urandom);
        it.new_key         = KEY_FIELD_W'($urandom);
        it.new_refcount    = CNT_FIELD_W'($urandom);
        it.requested_slots = REQ_W'(req);
        send_item(it);
    endtask

    // Waits until the block is idle, then writes the write-back register.
    task automatic set_write_back(input logic value);
        i_in_valid <= 1'b0;
        while (bucket_sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        bucket_sb.set_write_back(value);
        i_cfg_we <= 1'b0;
    endtask

    // Writes every slot as a sequence of runs of random keys.
    task automatic fill_bucket(input bit singles);
        int s;
        int k;
        int span;
        logic [KEY_BITS-1:0]   key;
        logic [COUNT_BITS-1:0] cnt;
        s = 0;
        while (s < NUM_SLOTS) begin
            span = singles ? 1 : $urandom_range(1, 6);
            key = KEY_BITS'($urandom);
            cnt = ($urandom_range(0, 1) == 1) ? COUNT_BITS'($urandom_range(0, 3))
                                               : COUNT_BITS'($urandom);
            for (k = 0; k < span && s < NUM_SLOTS; k++) begin
                send_write(s, 1'b1, key, (k == 0) ? cnt : COUNT_BITS'($urandom));
                s++;
            end
        end
    endtask

    task automatic run_episode();
        int n;
        int r;
        int req;
        if ($urandom_range(0, 9) < 3) begin
            fill_bucket($urandom_range(0, 3) == 0);
        end else begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                send_write($urandom_range(0, NUM_SLOTS - 1), $urandom_range(0, 4) != 0,
                           ($urandom_range(0, 1) == 1) ? KEY_BITS'($urandom_range(0, 2))
                                                       : KEY_BITS'($urandom),
                           COUNT_BITS'($urandom));
            end
        end
        r = $urandom_range(0, 19);
        if (r == 0)
            req = $urandom_range(NUM_SLOTS + 1, 63);
        else if (r == 1)
            req = 0;
        else if (r == 2)
            req = NUM_SLOTS;
        else
            req = $urandom_range(1, 12);
        send_alloc(req);
    endtask

    initial begin : stimulus
        bucket_sb = new();
        idle_on = 1'b1;
        hold_request = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = MODE_WRITE;
        i_slot_index = '0;
        i_new_valid = 1'b0;
        i_new_key = '0;
        i_new_refcount = '0;
        i_requested_slots = '0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_write_back(1'b1);
        send_alloc(0);
        send_alloc(NUM_SLOTS);
        send_alloc(NUM_SLOTS + 1);
        send_alloc(63);
        send_write(0, 1'b1, 16'h0000, 16'hFFFF);
        send_write(1, 1'b1, 16'h0000, 16'h0000);
        send_write(2, 1'b1, 16'hFFFF, 16'd5);
        send_write(3, 1'b1, 16'h1234, 16'd5);
        send_write(31, 1'b1, 16'hFFFF, 16'h0000);
        send_write(30, 1'b1, 16'hFFFF, 16'd7);
        send_write(16, 1'b1, 16'hAAAA, 16'd2);
        send_write(15, 1'b1, 16'h5555, 16'd3);
        send_alloc(1);
        send_alloc(14);
        send_write(20, 1'b1, 16'h0F0F, 16'd9);
        send_write(5, 1'b0, 16'hFFFF, 16'hFFFF);
        send_alloc(31);
        send_alloc(NUM_SLOTS);

        set_write_back(1'b0);
        idle_on = 1'b0;
        while (bucket_sb.n_items < 40) run_episode();

        set_write_back(1'b1);
        idle_on = 1'b1;
        fill_bucket(1'b1);
        hold_request = 1'b1;
        send_alloc(NUM_SLOTS);
        fill_bucket(1'b0);
        send_alloc(NUM_SLOTS);
        while (bucket_sb.n_items < 110) run_episode();

        set_write_back(1'b0);
        while (bucket_sb.n_items < 130) run_episode();

        i_in_valid <= 1'b0;
        while (bucket_sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        $display("Run covered %0d transfers in, %0d of them allocates, %0d evictions",
                 bucket_sb.n_items, bucket_sb.n_allocs, bucket_sb.n_evictions);
        $display("Checked %0d results across both write-back settings, %0d mismatches",
                 bucket_sb.n_checked, bucket_sb.n_errors);
        if (bucket_sb.n_errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
